>>> src/utc_to_local_dst_calendar_defines.svh
// ----------------------------------------------------------------------------
// UTC to local time converter - assertion macros
// Shared property wrappers for the checks inside the converter pipeline.
// ----------------------------------------------------------------------------
`ifndef UTC_TO_LOCAL_DST_CALENDAR_DEFINES_SVH
`define UTC_TO_LOCAL_DST_CALENDAR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UCAL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ucal check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define UCAL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ucal check failed: next-cycle implication");

`endif

>>> src/ucal_pkg.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - package
// Field widths, calendar constants, month table and inter-stage types.
// ----------------------------------------------------------------------------
package ucal_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int HOUR_W  = 5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [DAY_W-1:0]   SUMMER_DAY_MIN = 5'd25;
    localparam logic [HOUR_W:0]    LAST_HOUR      = 6'd23;
    localparam logic [HOUR_W:0]    HOURS_PER_DAY  = 6'd24;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] MARCH    = 4'd3;
    localparam logic [MONTH_W-1:0] APRIL    = 4'd4;
    localparam logic [MONTH_W-1:0] OCTOBER  = 4'd10;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    localparam logic [WDAY_W-1:0]  MONDAY = 3'd1;
    localparam logic [WDAY_W-1:0]  SUNDAY = 3'd7;

    // Undefined month codes count as 31 days
    localparam logic [DAY_W-1:0] MONTH_DAYS [0:15] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
    } ucal_in_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   month_last;
        logic               last_sunday;
        logic               past_last_sunday;
    } ucal_prep_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   month_last;
        logic               day_wrap;
        logic               summer;
    } ucal_offs_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
        logic               summer;
    } ucal_out_t;

endpackage

>>> src/ucal_prep.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - stage 1
// Month length lookup, leap February and last-Sunday tests.
// ----------------------------------------------------------------------------
module ucal_prep
    import ucal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ucal_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output ucal_prep_t out_data
);

    logic             valid_reg;
    ucal_prep_t       data_reg;
    ucal_prep_t       data_next;
    logic [WDAY_W-1:0] dow;
    logic             leap_feb;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        // 0 = Sunday; code 0 also counts as Sunday
        dow      = (in_data.weekday == SUNDAY) ? '0 : in_data.weekday;
        leap_feb = (in_data.month == FEBRUARY) && (in_data.year[1:0] == 2'b00);

        data_next.year       = in_data.year;
        data_next.month      = in_data.month;
        data_next.day        = in_data.day;
        data_next.weekday    = in_data.weekday;
        data_next.hour       = in_data.hour;
        data_next.month_last = MONTH_DAYS[in_data.month] + {{(DAY_W-1){1'b0}}, leap_feb};
        data_next.last_sunday = (in_data.day >= SUMMER_DAY_MIN) && (dow == '0);
        // most recent Sunday falls on or after the threshold day
        data_next.past_last_sunday = {1'b0, in_data.day} >=
                                     ({1'b0, SUMMER_DAY_MIN} + {3'b000, dow});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/ucal_offset.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - stage 2
// Summer-time decision, hour offset and day-wrap detection.
// ----------------------------------------------------------------------------
module ucal_offset
    import ucal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ucal_prep_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output ucal_offs_t out_data
);

    logic            valid_reg;
    ucal_offs_t      data_reg;
    ucal_offs_t      data_next;
    logic            summer;
    logic [HOUR_W:0] hour_sum;
    logic            wrap;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        if (in_data.month > MARCH && in_data.month < OCTOBER) begin
            summer = 1'b1;
        end else if (in_data.month == MARCH) begin
            summer = in_data.last_sunday ? (in_data.hour != '0) : in_data.past_last_sunday;
        end else if (in_data.month == OCTOBER) begin
            summer = in_data.last_sunday ? (in_data.hour == '0) : !in_data.past_last_sunday;
        end else begin
            summer = 1'b0;
        end

        hour_sum = {1'b0, in_data.hour} + (summer ? 6'd2 : 6'd1);
        wrap     = hour_sum > LAST_HOUR;

        data_next.year       = in_data.year;
        data_next.month      = in_data.month;
        data_next.day        = in_data.day;
        data_next.weekday    = in_data.weekday;
        data_next.month_last = in_data.month_last;
        data_next.hour       = wrap ? HOUR_W'(hour_sum - HOURS_PER_DAY) : hour_sum[HOUR_W-1:0];
        data_next.day_wrap   = wrap;
        data_next.summer     = summer;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/ucal_roll.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - stage 3
// Weekday, day, month and year rollover; output register.
// ----------------------------------------------------------------------------
module ucal_roll
    import ucal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ucal_offs_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output ucal_out_t  out_data
);

    logic      valid_reg;
    ucal_out_t data_reg;
    ucal_out_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.year    = in_data.year;
        data_next.month   = in_data.month;
        data_next.day     = in_data.day;
        data_next.weekday = in_data.weekday;
        data_next.hour    = in_data.hour;
        data_next.summer  = in_data.summer;

        if (in_data.day_wrap) begin
            data_next.weekday = (in_data.weekday == SUNDAY) ? MONDAY
                                                            : in_data.weekday + 3'd1;
            // any day at or past the month end starts the next month
            if (in_data.day >= in_data.month_last) begin
                data_next.day = 5'd1;
                if (in_data.month == DECEMBER) begin
                    data_next.month = JANUARY;
                    data_next.year  = in_data.year + 12'd1;
                end else begin
                    data_next.month = in_data.month + 4'd1;
                end
            end else begin
                data_next.day = in_data.day + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/utc_to_local_dst_calendar.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - top level
// UTC date and hour to Central European time with summer-time hour.
// ----------------------------------------------------------------------------
// Channel   Dir   Content
// s_*       in    UTC year, month, day, weekday, hour
// m_*       out   local year, month, day, weekday, hour, summer flag
//
// Three register stages (prep, offset, roll); m_tvalid rises once an accepted item reaches the roll register.
// One transaction per cycle sustained while m_tready stays high; each stage has its own valid bit.
// A stage takes new data when empty or when the stage after it moves on.
// aresetn (synchronous) clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`include "utc_to_local_dst_calendar_defines.svh"

module utc_to_local_dst_calendar
    import ucal_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] utc_year, [15:12] utc_month, [20:16] utc_day,
    // [23:21] utc_weekday, [28:24] utc_hour, [31:29] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] local_year, [15:12] local_month, [20:16] local_day,
    // [23:21] local_weekday, [28:24] local_hour, [29] summer_time, [31:30] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    ucal_in_t   in_item;
    ucal_prep_t prep_data;
    ucal_offs_t offs_data;
    ucal_out_t  out_item;
    logic       prep_valid;
    logic       prep_ready;
    logic       offs_valid;
    logic       offs_ready;

    assign in_item.year    = s_tdata[11:0];
    assign in_item.month   = s_tdata[15:12];
    assign in_item.day     = s_tdata[20:16];
    assign in_item.weekday = s_tdata[23:21];
    assign in_item.hour    = s_tdata[28:24];

    ucal_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    ucal_offset u_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (offs_valid),
        .out_ready (offs_ready),
        .out_data  (offs_data)
    );

    ucal_roll u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (offs_valid),
        .in_ready  (offs_ready),
        .in_data   (offs_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = {2'b00, out_item.summer, out_item.hour, out_item.weekday,
                      out_item.day, out_item.month, out_item.year};

    // input back-pressure only when every stage is full and the sink stalls
    `UCAL_ASSERT_NOW(a_full_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    // local hour always lands in a day
    `UCAL_ASSERT_NOW(a_hour_range, aclk, aresetn, m_tvalid, out_item.hour < 5'd24)
    // summer hour only from March to October, or November just after a wrap
    `UCAL_ASSERT_NOW(a_summer_month, aclk, aresetn, m_tvalid && out_item.summer,
        out_item.month >= MARCH && out_item.month <= 4'd11)
    // a full pipeline stalled at the sink keeps its output on the next edge
    `UCAL_ASSERT_NEXT(a_stall_keep, aclk, aresetn, !s_tready, m_tvalid)

endmodule

>>> verif/cet_check_pkg.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - checking package
// Field layout of both channels, a local-time predictor and the tracker that
// lines up UTC transactions with the local times that come back.
// ----------------------------------------------------------------------------
package cet_check_pkg;
    import ucal_pkg::*;

    localparam logic [MONTH_W-1:0] JUNE      = 4'd6;
    localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
    localparam logic [MONTH_W-1:0] NOVEMBER  = 4'd11;
    localparam logic [WDAY_W-1:0]  SATURDAY  = 3'd6;

    // Signed threshold, the Sunday search can go below zero
    localparam int LAST_SUNDAY_FROM = 25;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
    } utc_stamp_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
        logic               summer;
    } cet_stamp_t;

    function automatic logic [IN_DATA_W-1:0] pack_utc(logic [YEAR_W-1:0] year,
                                                      logic [MONTH_W-1:0] month,
                                                      logic [DAY_W-1:0] day,
                                                      logic [WDAY_W-1:0] weekday,
                                                      logic [HOUR_W-1:0] hour);
        return {3'b000, hour, weekday, day, month, year};
    endfunction

    function automatic utc_stamp_t unpack_utc(logic [IN_DATA_W-1:0] word);
        utc_stamp_t u;
        u.year    = word[11:0];
        u.month   = word[15:12];
        u.day     = word[20:16];
        u.weekday = word[23:21];
        u.hour    = word[28:24];
        return u;
    endfunction

    function automatic cet_stamp_t unpack_local(logic [OUT_DATA_W-1:0] word);
        cet_stamp_t c;
        c.year    = word[11:0];
        c.month   = word[15:12];
        c.day     = word[20:16];
        c.weekday = word[23:21];
        c.hour    = word[28:24];
        c.summer  = word[29];
        return c;
    endfunction

    // Undefined month codes are 31 days long; every fourth year is leap
    function automatic int unsigned month_length(logic [MONTH_W-1:0] month,
                                                 logic [YEAR_W-1:0] year);
        case (month)
            FEBRUARY:                          return (year[1:0] == 2'b00) ? 29 : 28;
            APRIL, JUNE, SEPTEMBER, NOVEMBER:  return 30;
            default:                           return 31;
        endcase
    endfunction

    function automatic cet_stamp_t predict_local(utc_stamp_t u);
        cet_stamp_t  c;
        int          dow;
        int          prev_sunday;
        bit          last_sunday;
        bit          summer;
        logic [5:0]  hr;

        // Weekday 0 and 7 both count as Sunday here
        dow         = int'(u.weekday) % 7;
        prev_sunday = int'(u.day) - dow;
        last_sunday = (int'(u.day) >= LAST_SUNDAY_FROM) && (dow == 0);

        if (u.month > MARCH && u.month < OCTOBER)
            summer = 1'b1;
        else if (u.month == MARCH)
            summer = last_sunday ? (u.hour > 0) : (prev_sunday >= LAST_SUNDAY_FROM);
        else if (u.month == OCTOBER)
            summer = last_sunday ? (u.hour < 1) : (prev_sunday < LAST_SUNDAY_FROM);
        else
            summer = 1'b0;

        c.year    = u.year;
        c.month   = u.month;
        c.day     = u.day;
        c.weekday = u.weekday;
        c.summer  = summer;
        hr = {1'b0, u.hour} + (summer ? 6'd2 : 6'd1);

        if (hr > 6'd23) begin
            hr        = hr - 6'd24;
            c.weekday = (u.weekday == SUNDAY) ? MONDAY : u.weekday + 3'd1;
            if (u.day >= month_length(u.month, u.year)) begin
                c.day = 5'd1;
                if (u.month == DECEMBER) begin
                    c.month = JANUARY;
                    c.year  = u.year + 12'd1;
                end else begin
                    c.month = u.month + 4'd1;
                end
            end else begin
                c.day = u.day + 5'd1;
            end
        end
        c.hour = hr[HOUR_W-1:0];
        return c;
    endfunction

    class local_time_tracker;
        cet_stamp_t  awaited[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        function void note_utc(logic [IN_DATA_W-1:0] word);
            awaited.push_back(predict_local(unpack_utc(word)));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_local(logic [OUT_DATA_W-1:0] word);
            cet_stamp_t want;
            cet_stamp_t got;
            got = unpack_local(word);
            if (awaited.size() == 0) begin
                $error("local time transaction %h with no UTC transaction pending", word);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("local_year",    want.year,    got.year);
            compare_field("local_month",   want.month,   got.month);
            compare_field("local_day",     want.day,     got.day);
            compare_field("local_weekday", want.weekday, got.weekday);
            compare_field("local_hour",    want.hour,    got.hour);
            compare_field("summer_time",   want.summer,  got.summer);
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// UTC to local time converter - testbench top
// Directed calendar corners, then mostly well-formed random timestamps with
// some raw noise, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ucal_pkg::*;
    import cet_check_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1100;
    localparam int TAIL_CYCLES  = 12;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    local_time_tracker tracker = new();
    idle_mode_t        send_idle = IDLE_LIGHT;
    idle_mode_t        recv_idle = IDLE_LIGHT;
    bit                hold_output = 1'b0;

    utc_to_local_dst_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            default:    return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_utc();
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dy;
        logic [WDAY_W-1:0]  wd;
        logic [HOUR_W-1:0]  hr;
        int unsigned        len;

        // Raw noise reaches undefined months, day 0, weekday 0 and late hours
        if ($urandom_range(0, 4) == 0)
            return pack_utc(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                            WDAY_W'($urandom), HOUR_W'($urandom));

        yr = ($urandom_range(0, 7) == 0) ? {YEAR_W{1'b1}} : YEAR_W'($urandom);
        case ($urandom_range(0, 5))
            0:       mo = MARCH;
            1:       mo = OCTOBER;
            2:       mo = DECEMBER;
            3:       mo = FEBRUARY;
            default: mo = MONTH_W'($urandom_range(1, 12));
        endcase
        len = month_length(mo, yr);
        // Month ends matter for both the last-Sunday test and the rollover
        dy = DAY_W'($urandom_range(0, 1) ? $urandom_range(22, len) : $urandom_range(1, len));
        wd = ($urandom_range(0, 2) == 0) ? SUNDAY : WDAY_W'($urandom_range(1, 7));
        case ($urandom_range(0, 3))
            0:       hr = HOUR_W'($urandom_range(21, 23));
            1:       hr = HOUR_W'($urandom_range(0, 1));
            default: hr = HOUR_W'($urandom_range(0, 23));
        endcase
        return pack_utc(yr, mo, dy, wd, hr);
    endfunction

    task automatic send_utc(input logic [IN_DATA_W-1:0] word);
        int gap;
        gap = draw_wait(send_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        tracker.note_utc(word);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        int taken;
        taken = 0;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (taken % 80 == 0)
                recv_idle = idle_mode_t'($urandom_range(0, 2));
            if (hold_output) begin
                hold_output = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_wait(recv_idle);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            tracker.check_local(m_tdata);
            taken++;
        end
    end

    initial begin
        int n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Calendar corners
        send_utc(pack_utc(12'd0,    JANUARY,   5'd1,  MONDAY,   5'd0));
        send_utc(pack_utc(12'd4095, DECEMBER,  5'd31, 3'd5,     5'd23));
        send_utc(pack_utc(12'd2024, FEBRUARY,  5'd28, 3'd3,     5'd23));
        send_utc(pack_utc(12'd2024, FEBRUARY,  5'd29, 3'd4,     5'd23));
        send_utc(pack_utc(12'd2023, FEBRUARY,  5'd28, 3'd2,     5'd23));
        // Spring switch on the last Sunday, either side of 01:00 UTC
        send_utc(pack_utc(12'd2024, MARCH,     5'd31, SUNDAY,   5'd0));
        send_utc(pack_utc(12'd2024, MARCH,     5'd31, SUNDAY,   5'd1));
        send_utc(pack_utc(12'd2030, MARCH,     5'd25, SUNDAY,   5'd1));
        send_utc(pack_utc(12'd2024, MARCH,     5'd24, SUNDAY,   5'd12));
        send_utc(pack_utc(12'd2024, MARCH,     5'd30, SATURDAY, 5'd23));
        send_utc(pack_utc(12'd2024, MARCH,     5'd26, MONDAY,   5'd3));
        // Autumn switch
        send_utc(pack_utc(12'd2024, OCTOBER,   5'd27, SUNDAY,   5'd0));
        send_utc(pack_utc(12'd2024, OCTOBER,   5'd27, SUNDAY,   5'd1));
        send_utc(pack_utc(12'd2024, OCTOBER,   5'd26, SATURDAY, 5'd22));
        send_utc(pack_utc(12'd2024, APRIL,     5'd30, 3'd2,     5'd22));
        send_utc(pack_utc(12'd2024, SEPTEMBER, 5'd30, MONDAY,   5'd23));
        // Weekday zero behaves as Sunday and steps to Monday
        send_utc(pack_utc(12'd2024, MARCH,     5'd31, 3'd0,     5'd5));
        send_utc(pack_utc(12'd2025, JANUARY,   5'd5,  3'd0,     5'd23));
        // Undefined months, out-of-range days and hours
        send_utc(pack_utc(12'd2025, 4'd0,      5'd31, 3'd3,     5'd23));
        send_utc(pack_utc(12'd2025, 4'd13,     5'd31, 3'd3,     5'd23));
        send_utc(pack_utc(12'd4095, 4'd15,     5'd31, SUNDAY,   5'd23));
        send_utc(pack_utc(12'd2025, APRIL,     5'd31, 3'd4,     5'd23));
        send_utc(pack_utc(12'd2025, JUNE,      5'd0,  3'd5,     5'd23));
        send_utc(pack_utc(12'd2025, JUNE,      5'd15, SATURDAY, 5'd31));
        send_utc(pack_utc(12'd2025, NOVEMBER,  5'd30, SUNDAY,   5'd24));

        // Back-to-back offers while the output is held off, so the pipe backs up
        hold_output = 1'b1;
        send_idle   = IDLE_NONE;
        repeat (60) send_utc(random_utc());

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                send_idle = idle_mode_t'($urandom_range(0, 2));
            send_utc(random_utc());
        end
        s_tvalid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/ucal_pkg.sv
src/ucal_prep.sv
src/ucal_offset.sv
src/ucal_roll.sv
src/utc_to_local_dst_calendar.sv
verif/cet_check_pkg.sv
verif/tb_top.sv
